@@ sv/gbn_pkg.sv @@
// Shared types and constants for the go-back-N sender window.
package gbn_pkg;

    // Opcodes of an incoming request.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] CFG_FRAME_COUNT   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam int CFG_DATA_W = 32;

    // Configuration values after reset.
    localparam logic [3:0]  WINDOW_SIZE_RST   = 4'd4;
    localparam logic [15:0] FRAME_COUNT_RST   = 16'd10000;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

    // One incoming request as seen on the input port.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] ack_number;
        logic        ack_corrupt;
    } in_item_t;

    // One result as seen on the output port.
    typedef struct packed {
        logic        send_valid;
        logic [15:0] frame_number;
        logic        timeout_fired;
        logic [15:0] acked_total;
        logic        all_done;
    } out_item_t;

    // Class of a request after decoding in the front end.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TICK,
        KIND_SEND,
        KIND_ACK
    } cmd_kind_t;

    // Decoded command passed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] ack_number;
    } cmd_t;

endpackage

@@ sv/gbn_front.sv @@
// Front end: accepts requests, classifies them and queues the commands.
module gbn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  gbn_pkg::in_item_t item,
    output logic             cmd_valid,
    output gbn_pkg::cmd_t    cmd,
    input  logic             cmd_take
);
    import gbn_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       slots_reg [DEPTH];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       do_write;
    logic       do_read;
    cmd_t       decoded;

    // Classify the request; a corrupt acknowledgement becomes a no-op command here.
    always_comb
    begin
        decoded.ack_number = item.ack_number;
        unique case (item.opcode)
            OP_TICK: decoded.kind = KIND_TICK;
            OP_SEND: decoded.kind = KIND_SEND;
            OP_ACK:  decoded.kind = item.ack_corrupt ? KIND_NONE : KIND_ACK;
            default: decoded.kind = KIND_NONE;
        endcase
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slots_reg[rd_ptr_reg];
    assign do_write  = push && !full;
    assign do_read   = cmd_take && cmd_valid;

    // Occupancy of the command queue.
    always_comb
    begin
        count_next = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_write)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_read)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slots_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ sv/gbn_resq.sv @@
// Result queue between the back end and the output port.
module gbn_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  gbn_pkg::out_item_t res_in,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output gbn_pkg::out_item_t result
);
    import gbn_pkg::*;

    localparam int DEPTH = 2;

    out_item_t  slots_reg [DEPTH];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       do_write;
    logic       do_read;

    assign res_full = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign result   = slots_reg[rd_ptr_reg];
    assign do_write = res_push && !res_full;
    assign do_read  = pop && !empty;

    // Occupancy of the result queue.
    always_comb
    begin
        count_next = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_write)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_read)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slots_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

@@ sv/gbn_back.sv @@
// Back end: window state, send stamps, timer and configuration registers.
module gbn_back #(
    parameter int WINDOW_MAX = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              cmd_valid,
    input  gbn_pkg::cmd_t                     cmd,
    output logic                              cmd_take,
    output logic                              res_push,
    output gbn_pkg::out_item_t                res,
    input  logic                              res_full
);
    import gbn_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [6:0]     WIN_MAX_V = 7'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);
    localparam logic [IDX_W:0] IDX_WRAP  = (IDX_W + 1)'(WINDOW_MAX);

    // Configuration registers.
    logic [3:0]  win_size_reg;
    logic [15:0] frame_count_reg;
    logic [31:0] timeout_reg;

    // Window state.
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [15:0]          base_reg, base_next;
    logic [15:0]          next_reg, next_next;
    logic [15:0]          deliv_reg, deliv_next;
    logic [IDX_W-1:0]     base_idx_reg, base_idx_next;
    logic [IDX_W-1:0]     next_idx_reg, next_idx_next;

    // Send stamps and the registered stamp of the window base frame.
    logic [TIME_BITS-1:0] stamp_mem [WINDOW_MAX];
    logic [TIME_BITS-1:0] stamp_reg;
    logic                 stamp_we;

    logic [6:0]           eff_win;
    logic [16:0]          last_sum;
    logic [15:0]          win_last;
    logic [15:0]          outstanding;
    logic                 can_send;
    logic                 ack_ok;
    logic [15:0]          ack_delta;
    logic [IDX_W:0]       idx_sum;
    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fire;

    assign cmd_take = cmd_valid && !res_full;
    assign res_push = cmd_take;

    // Effective window: zero acts as one, large values clip to the maximum.
    always_comb
    begin
        if (win_size_reg == 4'd0)
        begin
            eff_win = 7'd1;
        end
        else if ({3'b000, win_size_reg} > WIN_MAX_V)
        begin
            eff_win = WIN_MAX_V;
        end
        else
        begin
            eff_win = {3'b000, win_size_reg};
        end
    end

    // Last frame in the window, clipped to the frame total.
    assign last_sum = {1'b0, base_reg} + 17'(eff_win) - 17'd1;

    always_comb
    begin
        if (frame_count_reg == 16'd0)
        begin
            win_last = 16'd0;
        end
        else if (last_sum >= {1'b0, frame_count_reg})
        begin
            win_last = frame_count_reg - 16'd1;
        end
        else
        begin
            win_last = last_sum[15:0];
        end
    end

    // Send, acknowledgement and timeout conditions.
    assign outstanding = next_reg - base_reg;
    assign can_send    = (next_reg <= win_last) && (next_reg < frame_count_reg)
                         && (outstanding < 16'(eff_win));
    assign ack_ok      = (cmd.ack_number > base_reg) && (cmd.ack_number <= next_reg);
    assign ack_delta   = cmd.ack_number - base_reg;
    assign idx_sum     = {1'b0, base_idx_reg} + ack_delta[IDX_W:0];
    assign time_inc    = time_reg + TIME_BITS'(1);
    assign elapsed     = time_inc - stamp_reg;
    assign fire        = (next_reg != base_reg)
                         && (CMP_W'(elapsed) >= CMP_W'(timeout_reg));

    // Execute one command and form its result.
    always_comb
    begin
        time_next         = time_reg;
        base_next         = base_reg;
        next_next         = next_reg;
        deliv_next        = deliv_reg;
        base_idx_next     = base_idx_reg;
        next_idx_next     = next_idx_reg;
        stamp_we          = 1'b0;
        res.send_valid    = 1'b0;
        res.frame_number  = 16'd0;
        res.timeout_fired = 1'b0;
        if (cmd_take)
        begin
            unique case (cmd.kind)
                KIND_TICK:
                begin
                    time_next = time_inc;
                    if (fire)
                    begin
                        next_next         = base_reg;
                        next_idx_next     = base_idx_reg;
                        res.timeout_fired = 1'b1;
                    end
                end
                KIND_SEND:
                begin
                    if (can_send)
                    begin
                        stamp_we         = 1'b1;
                        res.send_valid   = 1'b1;
                        res.frame_number = next_reg;
                        next_next        = next_reg + 16'd1;
                        next_idx_next    = (next_idx_reg == IDX_LAST) ?
                                           '0 : next_idx_reg + IDX_W'(1);
                    end
                end
                KIND_ACK:
                begin
                    if (ack_ok)
                    begin
                        deliv_next    = deliv_reg + ack_delta;
                        base_next     = cmd.ack_number;
                        base_idx_next = (idx_sum >= IDX_WRAP) ?
                                        IDX_W'(idx_sum - IDX_WRAP) : idx_sum[IDX_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.acked_total = deliv_next;
        res.all_done    = (deliv_next >= frame_count_reg);
    end

    // State registers and configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg    <= WINDOW_SIZE_RST;
            frame_count_reg <= FRAME_COUNT_RST;
            timeout_reg     <= TIMEOUT_TICKS_RST;
            time_reg        <= '0;
            base_reg        <= 16'd0;
            next_reg        <= 16'd0;
            deliv_reg       <= 16'd0;
            base_idx_reg    <= '0;
            next_idx_reg    <= '0;
        end
        else
        begin
            time_reg     <= time_next;
            base_reg     <= base_next;
            next_reg     <= next_next;
            deliv_reg    <= deliv_next;
            base_idx_reg <= base_idx_next;
            next_idx_reg <= next_idx_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE:   win_size_reg    <= cfg_wdata[3:0];
                    CFG_FRAME_COUNT:   frame_count_reg <= cfg_wdata[15:0];
                    CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_wdata[31:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Stamp memory; the base stamp is read ahead, with a bypass for a fresh write.
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[next_idx_reg] <= time_reg;
        end
        if (stamp_we && (next_idx_reg == base_idx_next))
        begin
            stamp_reg <= time_reg;
        end
        else
        begin
            stamp_reg <= stamp_mem[base_idx_next];
        end
    end

endmodule

@@ sv/go_back_n_sender_window.sv @@
// Top level of the go-back-N sender window.
//
//  Channel   Handshake         Payload        Meaning
//  input     push / full       item           tick, send slot or acknowledgement
//  result    pop / empty       result         one result per request, in order
//  config    cfg_we            cfg_index/data window size, frame total, timeout
//
// A request is taken every cycle while full is low; its result reaches the result
// port through a two-entry command queue and a two-entry result queue, both
// registered. The window update is formed by combinational compares and adds, and
// the base stamp is read ahead from the stamp memory into a register.
// Reset is asynchronous and needs no clearing pass. full rises only when the
// result side has stalled long enough to fill both queues.
module go_back_n_sender_window #(
    parameter int WINDOW_MAX = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  gbn_pkg::in_item_t              item,
    output logic                           empty,
    input  logic                           pop,
    output gbn_pkg::out_item_t             result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gbn_pkg::*;

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_take;
    logic      res_push;
    out_item_t res;
    logic      res_full;

    // Accept and classify requests.
    gbn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Window state machine and timer.
    gbn_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // Results wait here until popped.
    gbn_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

@@ tb/gbn_window_checker.sv @@
// Checker for the go-back-N sender window: tracks the window, predicts each result and compares.
`timescale 1ns / 1ps

module gbn_window_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  gbn_pkg::in_item_t              item,
    input  logic                           empty,
    input  logic                           pop,
    input  gbn_pkg::out_item_t             result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen,
    output int                             frames_sent,
    output int                             go_backs,
    output int                             done_results,
    output logic [15:0]                    base_hint,
    output logic [15:0]                    next_hint
);
    import gbn_pkg::*;

    localparam int SLOTS      = 8;
    localparam int PRINT_CAP  = 100;

    // Configuration as the block should hold it.
    logic [3:0]  win_reg;
    logic [15:0] total_reg;
    logic [31:0] tmo_reg;

    // Window state of the sender.
    logic [31:0] now_ticks;
    logic [15:0] base_frame;
    logic [15:0] last_frame;
    logic [15:0] next_frame;
    logic [15:0] acked;
    logic [31:0] stamps [SLOTS];

    // Results still owed by the block, oldest first.
    out_item_t   owed_q [$];

    // Counts a mismatch and prints a line for it while under the print cap.
    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int idx,
                               input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
        begin
            flag($sformatf("result %0d: %s is %0h, should be %0h", idx, name, got, want));
        end
    endtask

    // Window width in use: zero acts as one, anything above the slot count is clipped.
    function automatic int eff_window();
        if (win_reg == 4'd0)
        begin
            return 1;
        end
        if (int'(win_reg) > SLOTS)
        begin
            return SLOTS;
        end
        return int'(win_reg);
    endfunction

    // Last frame of the window, clipped to the frame total.
    function automatic logic [15:0] window_end();
        int e;
        e = int'(base_frame) + eff_window() - 1;
        if (total_reg == 16'd0)
        begin
            e = 0;
        end
        else if (e >= int'(total_reg))
        begin
            e = int'(total_reg) - 1;
        end
        return e[15:0];
    endfunction

    // Applies one request to the window and returns the result it should give.
    function automatic out_item_t advance_window(input in_item_t req);
        out_item_t   res;
        logic [31:0] waited;
        res = '0;
        case (req.opcode)
            OP_TICK:
            begin
                now_ticks = now_ticks + 32'd1;
                if (next_frame != base_frame)
                begin
                    waited = now_ticks - stamps[base_frame % SLOTS];
                    if (waited >= tmo_reg)
                    begin
                        next_frame = base_frame;
                        res.timeout_fired = 1'b1;
                    end
                end
            end
            OP_SEND:
            begin
                if (next_frame <= last_frame && next_frame < total_reg &&
                    (int'(next_frame) - int'(base_frame)) < eff_window())
                begin
                    stamps[next_frame % SLOTS] = now_ticks;
                    res.send_valid = 1'b1;
                    res.frame_number = next_frame;
                    next_frame = next_frame + 16'd1;
                end
            end
            OP_ACK:
            begin
                if (!req.ack_corrupt && req.ack_number > base_frame &&
                    req.ack_number <= next_frame)
                begin
                    acked = acked + (req.ack_number - base_frame);
                    base_frame = req.ack_number;
                    last_frame = window_end();
                end
            end
            default:
            begin
            end
        endcase
        res.acked_total = acked;
        res.all_done = (acked >= total_reg);
        return res;
    endfunction

    // Register writes; window size and frame total move the window end.
    task automatic apply_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW_SIZE:
            begin
                win_reg = data[3:0];
                last_frame = window_end();
            end
            CFG_FRAME_COUNT:
            begin
                total_reg = data[15:0];
                last_frame = window_end();
            end
            CFG_TIMEOUT_TICKS:
            begin
                tmo_reg = data;
            end
            default:
            begin
            end
        endcase
    endtask

    // Watch all three ports at each edge: results first, then writes, then requests.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t pred;
        if (!rst_n)
        begin
            win_reg = WINDOW_SIZE_RST;
            total_reg = FRAME_COUNT_RST;
            tmo_reg = TIMEOUT_TICKS_RST;
            now_ticks = '0;
            base_frame = '0;
            next_frame = '0;
            acked = '0;
            last_frame = window_end();
            owed_q.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            frames_sent = 0;
            go_backs = 0;
            done_results = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (owed_q.size() == 0)
                begin
                    flag($sformatf("result %0d arrived with nothing owed", results_seen));
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("send_valid", results_seen, result.send_valid,
                                want.send_valid);
                    check_field("frame_number", results_seen, result.frame_number,
                                want.frame_number);
                    check_field("timeout_fired", results_seen, result.timeout_fired,
                                want.timeout_fired);
                    check_field("acked_total", results_seen, result.acked_total,
                                want.acked_total);
                    check_field("all_done", results_seen, result.all_done,
                                want.all_done);
                end
            end
            if (cfg_we)
            begin
                apply_write(cfg_index, cfg_wdata);
            end
            if (push && !full)
            begin
                pred = advance_window(item);
                owed_q.push_back(pred);
                if (pred.send_valid)
                begin
                    frames_sent++;
                end
                if (pred.timeout_fired)
                begin
                    go_backs++;
                end
                if (pred.all_done)
                begin
                    done_results++;
                end
            end
            pending = owed_q.size();
        end
        base_hint = base_frame;
        next_hint = next_frame;
    end

endmodule

@@ tb/go_back_n_sender_window_tb.sv @@
// Testbench top for the go-back-N sender window: reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module go_back_n_sender_window_tb;
    import gbn_pkg::*;

    // Request code with no effect on the window.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int PHASES        = 10;
    localparam int PHASE_REQS    = 75;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 48;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int LIMIT         = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    in_item_t              item = '0;
    logic                  full;
    logic                  empty;
    out_item_t             result;

    int                    fail_count;
    int                    pending;
    int                    results_seen;
    int                    frames_sent;
    int                    go_backs;
    int                    done_results;
    logic [15:0]           base_hint;
    logic [15:0]           next_hint;

    logic                  calm = 1'b0;
    logic                  hold_ask = 1'b0;
    bit                    held = 1'b0;
    int                    cycles = 0;

    go_back_n_sender_window u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gbn_window_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .empty        (empty),
        .pop          (pop),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .frames_sent  (frames_sent),
        .go_backs     (go_backs),
        .done_results (done_results),
        .base_hint    (base_hint),
        .next_hint    (next_hint)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results owed.", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none near the end.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_ask && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one request, already set up at a falling edge, until it is taken.
    task automatic drive(input in_item_t req);
        push <= 1'b1;
        item <= req;
        do
        begin
            @(posedge clk);
        end
        while (full);
    endtask

    task automatic send_fixed(input logic [1:0] op, input logic [15:0] ack, input logic bad);
        in_item_t req;
        req.opcode = op;
        req.ack_number = ack;
        req.ack_corrupt = bad;
        @(negedge clk);
        drive(req);
    endtask

    task automatic idle_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // Waits until every owed result is out and the pipeline has drained.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all three registers; unused upper bits carry noise.
    task automatic configure(input logic [3:0] win, input logic [15:0] total,
                             input logic [31:0] tmo);
        logic [31:0] data;
        data = $urandom;
        data[3:0] = win;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_wdata <= data;
        data = $urandom;
        data[15:0] = total;
        @(negedge clk);
        cfg_index <= CFG_FRAME_COUNT;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_wdata <= tmo;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random request, mostly ticks, send slots and in-window acks; the rest is noise.
    function automatic in_item_t random_req();
        in_item_t req;
        int       r;
        int       span;
        req.ack_number = 16'($urandom_range(0, 65535));
        req.ack_corrupt = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            req.opcode = OP_TICK;
        end
        else if (r < 65)
        begin
            req.opcode = OP_SEND;
        end
        else if (r < 96)
        begin
            req.opcode = OP_ACK;
            req.ack_corrupt = 1'b0;
            span = int'(next_hint) - int'(base_hint);
            r = $urandom_range(0, 9);
            if (span > 0 && r < 7)
            begin
                req.ack_number = base_hint + 16'($urandom_range(1, span));
            end
            else if (r == 7)
            begin
                req.ack_number = 16'($urandom_range(0, base_hint));
            end
            else if (r == 8 && next_hint != 16'hFFFF)
            begin
                req.ack_number = 16'($urandom_range(int'(next_hint) + 1, 65535));
            end
            else
            begin
                req.ack_corrupt = 1'b1;
                if (span > 0)
                begin
                    req.ack_number = base_hint + 16'd1;
                end
            end
        end
        else
        begin
            req.opcode = OP_NONE;
        end
        return req;
    endfunction

    // Main sequence.
    initial
    begin
        int          p;
        int          n;
        logic [3:0]  win;
        logic [15:0] total;
        logic [31:0] tmo;
        int          top_total;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: idle code, window full, each kind of rejected ack, then a good one.
        send_fixed(OP_NONE, 16'hFFFF, 1'b1);
        repeat (5) send_fixed(OP_SEND, 16'h0000, 1'b0);
        send_fixed(OP_ACK, 16'd2, 1'b1);
        send_fixed(OP_ACK, 16'd0, 1'b0);
        send_fixed(OP_ACK, 16'hFFFF, 1'b0);
        send_fixed(OP_ACK, 16'd2, 1'b0);
        repeat (2) send_fixed(OP_SEND, 16'h0000, 1'b0);
        send_fixed(OP_TICK, 16'h5A5A, 1'b1);

        // Oversized window, short transfer, zero timeout: go-back on the first tick.
        settle();
        configure(4'd15, 16'd7, 32'd0);
        send_fixed(OP_TICK, 16'h0000, 1'b0);
        repeat (6) send_fixed(OP_SEND, 16'hA5A5, 1'b0);
        send_fixed(OP_ACK, 16'd7, 1'b0);
        send_fixed(OP_SEND, 16'h0000, 1'b0);

        // Zero window and zero frame total: nothing may be sent.
        settle();
        configure(4'd0, 16'd0, 32'hFFFF_FFFF);
        send_fixed(OP_SEND, 16'h0000, 1'b0);
        send_fixed(OP_TICK, 16'h0000, 1'b0);

        // Window of one, full frame range, timeout of one tick.
        settle();
        configure(4'd1, 16'hFFFF, 32'd1);
        send_fixed(OP_SEND, 16'h0000, 1'b0);
        send_fixed(OP_TICK, 16'h0000, 1'b0);
        send_fixed(OP_SEND, 16'h0000, 1'b0);
        send_fixed(OP_ACK, 16'd8, 1'b0);

        // Random phases, each under its own settings.
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            top_total = int'(base_hint) + $urandom_range(1, 40);
            if (top_total > 65535)
            begin
                top_total = 65535;
            end
            case (p)
                0:
                begin
                    win = 4'd8;
                    total = top_total[15:0];
                    tmo = 32'd5;
                end
                1:
                begin
                    win = 4'd1;
                    total = top_total[15:0];
                    tmo = 32'd1;
                end
                2:
                begin
                    win = 4'd15;
                    total = 16'hFFFF;
                    tmo = 32'd0;
                end
                3:
                begin
                    win = 4'd0;
                    total = 16'd0;
                    tmo = 32'hFFFF_FFFF;
                end
                4:
                begin
                    win = 4'd3;
                    total = 16'd1;
                    tmo = 32'd2;
                end
                default:
                begin
                    win = 4'($urandom_range(1, 8));
                    total = top_total[15:0];
                    tmo = $urandom_range(1, 30);
                end
            endcase
            configure(win, total, tmo);
            if (p == PHASES - 1)
            begin
                calm <= 1'b1;
            end
            for (n = 0; n < PHASE_REQS; n++)
            begin
                if (p != PHASES - 1 && $urandom_range(0, 9) == 0)
                begin
                    idle_input($urandom_range(1, 6));
                end
                if (p == HOLD_PHASE && n == 10)
                begin
                    hold_ask <= 1'b1;
                end
                @(negedge clk);
                drive(random_req());
            end
        end

        // Drain and close.
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d frames sent, %0d go-backs, %0d with transfer done.",
                 results_seen, frames_sent, go_backs, done_results);
        $display("Settings ranged over windows 0 to 15, totals 0 to 65535, timeouts 0 to max.");
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches found.", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ go_back_n_sender_window.f @@
sv/gbn_pkg.sv
sv/gbn_front.sv
sv/gbn_resq.sv
sv/gbn_back.sv
sv/go_back_n_sender_window.sv
tb/gbn_window_checker.sv
tb/go_back_n_sender_window_tb.sv
